// File: src/input_event_ring_queue_assert.svh
// ----------------------------------------------------------------------------
// Input event ring queue assertion macros
// Concurrent assertion wrappers that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef INPUT_EVENT_RING_QUEUE_ASSERT_SVH
`define INPUT_EVENT_RING_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define IEQ_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ring queue check failed");

// Next-cycle implication.
`define IEQ_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ring queue check failed");

`else

`define IEQ_ASSERT_NOW(name, clk, rst, ante, cons)
`define IEQ_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// File: src/ieq_pkg.sv
// ----------------------------------------------------------------------------
// Input event ring queue package
// Field widths, command and type codes, and the stored entry layout.
// ----------------------------------------------------------------------------
package ieq_pkg;

  localparam int TIME_W   = 31;
  localparam int TYPE_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int LENGTH_W = 16;
  localparam int HANDLE_W = 32;

  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_DEQUEUE = 1'b1;

  localparam logic [TYPE_W-1:0] TYPE_NONE  = 3'd0;
  localparam logic [TYPE_W-1:0] TYPE_MOUSE = 3'd3;

  typedef struct packed {
    logic        [TIME_W-1:0]   etime;
    logic        [TYPE_W-1:0]   etype;
    logic signed [VALUE_W-1:0]  first_value;
    logic signed [VALUE_W-1:0]  second_value;
    logic        [LENGTH_W-1:0] length;
    logic        [HANDLE_W-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic                       event_present;
    logic        [TIME_W-1:0]   out_time;
    logic        [TYPE_W-1:0]   out_type;
    logic signed [VALUE_W-1:0]  out_first_value;
    logic signed [VALUE_W-1:0]  out_second_value;
    logic        [LENGTH_W-1:0] out_payload_length;
    logic        [HANDLE_W-1:0] out_payload_handle;
    logic                       merged;
    logic                       overflow_dropped;
    logic        [HANDLE_W-1:0] dropped_payload_handle;
  } result_t;

endpackage

// File: src/ieq_cmd_if.sv
// ----------------------------------------------------------------------------
// Input event ring queue command channel
// Valid/ready channel carrying one enqueue or dequeue command.
// ----------------------------------------------------------------------------
interface ieq_cmd_if;

  logic                                valid;
  logic                                ready;
  logic                                command;
  logic        [ieq_pkg::TIME_W-1:0]   event_time;
  logic        [ieq_pkg::TYPE_W-1:0]   event_type;
  logic signed [ieq_pkg::VALUE_W-1:0]  first_value;
  logic signed [ieq_pkg::VALUE_W-1:0]  second_value;
  logic        [ieq_pkg::LENGTH_W-1:0] payload_length;
  logic        [ieq_pkg::HANDLE_W-1:0] payload_handle;
  logic        [ieq_pkg::TIME_W-1:0]   now_time;

  modport source (
    output valid, command, event_time, event_type, first_value, second_value,
           payload_length, payload_handle, now_time,
    input  ready
  );

  modport sink (
    input  valid, command, event_time, event_type, first_value, second_value,
           payload_length, payload_handle, now_time,
    output ready
  );

endinterface

// File: src/ieq_res_if.sv
// ----------------------------------------------------------------------------
// Input event ring queue result channel
// Valid/ready channel carrying one result per command.
// ----------------------------------------------------------------------------
interface ieq_res_if;

  logic                                valid;
  logic                                ready;
  logic                                event_present;
  logic        [ieq_pkg::TIME_W-1:0]   out_time;
  logic        [ieq_pkg::TYPE_W-1:0]   out_type;
  logic signed [ieq_pkg::VALUE_W-1:0]  out_first_value;
  logic signed [ieq_pkg::VALUE_W-1:0]  out_second_value;
  logic        [ieq_pkg::LENGTH_W-1:0] out_payload_length;
  logic        [ieq_pkg::HANDLE_W-1:0] out_payload_handle;
  logic                                merged;
  logic                                overflow_dropped;
  logic        [ieq_pkg::HANDLE_W-1:0] dropped_payload_handle;

  modport source (
    output valid, event_present, out_time, out_type, out_first_value,
           out_second_value, out_payload_length, out_payload_handle, merged,
           overflow_dropped, dropped_payload_handle,
    input  ready
  );

  modport sink (
    input  valid, event_present, out_time, out_type, out_first_value,
           out_second_value, out_payload_length, out_payload_handle, merged,
           overflow_dropped, dropped_payload_handle,
    output ready
  );

endinterface

// File: src/input_event_ring_queue.sv
// ----------------------------------------------------------------------------
// Input event ring queue
// Circular event queue with mouse motion coalescing and drop-oldest overflow.
// ----------------------------------------------------------------------------
//
//   Channel  Modport  Carries
//   cmd_ch   sink     enqueue/dequeue command with event fields and now_time
//   res_ch   source   one result per command: dequeued event or enqueue status
//
// One command per cycle is accepted; its result appears in the output
// register on the next cycle. The oldest entry is prefetched from the entry
// memory every cycle, and the newest entry is kept in a register, so each
// command needs only one memory write. Reset clears the pointers and the
// output valid; the memory is not cleared. A stalled result register holds
// off new commands until it is taken.
// ----------------------------------------------------------------------------
`include "input_event_ring_queue_assert.svh"

module input_event_ring_queue #(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  ieq_cmd_if.sink    cmd_ch,
  ieq_res_if.source  res_ch
);

  localparam int PW = $clog2(2 * QUEUE_DEPTH);
  localparam int SW = $clog2(QUEUE_DEPTH);
  localparam logic [PW-1:0] PTR_LAST = PW'(2 * QUEUE_DEPTH - 1);
  localparam logic [PW-1:0] SPAN_P   = PW'(2 * QUEUE_DEPTH);
  localparam logic [PW-1:0] DEPTH_P  = PW'(QUEUE_DEPTH);

  ieq_pkg::entry_t mem [QUEUE_DEPTH];
  ieq_pkg::entry_t mem_rdata;
  ieq_pkg::entry_t tail;
  ieq_pkg::entry_t tail_next;
  ieq_pkg::entry_t head;
  ieq_pkg::entry_t new_entry;
  ieq_pkg::entry_t merged_entry;
  ieq_pkg::entry_t wr_data;
  ieq_pkg::result_t res;
  ieq_pkg::result_t res_next;

  logic [PW-1:0] wp;
  logic [PW-1:0] wp_next;
  logic [PW-1:0] rp;
  logic [PW-1:0] rp_next;
  logic [PW-1:0] wp_prev;
  logic [PW-1:0] fill;
  logic [SW-1:0] wr_slot;
  logic [SW-1:0] newest_slot;
  logic [SW-1:0] wr_addr;
  logic [SW-1:0] rd_addr;
  logic          hit;
  logic          hit_next;
  logic          res_valid;
  logic          accept;
  logic          is_enq;
  logic          empty;
  logic          full;
  logic          do_merge;
  logic          wr_en;

  assign accept = cmd_ch.valid && cmd_ch.ready;
  assign is_enq = (cmd_ch.command == ieq_pkg::CMD_ENQUEUE);

  // Pointers run modulo twice the depth; the entry index folds them back.
  always_comb begin
    fill = (wp - rp) + ((wp < rp) ? SPAN_P : '0);
    empty = (fill == '0);
    full = (fill == DEPTH_P);
    wp_prev = (wp == '0) ? PTR_LAST : (wp - 1'b1);
    wr_slot = SW'((wp >= DEPTH_P) ? (wp - DEPTH_P) : wp);
    newest_slot = SW'((wp_prev >= DEPTH_P) ? (wp_prev - DEPTH_P) : wp_prev);
  end

  always_comb begin
    new_entry.etime = (cmd_ch.event_time == '0) ? cmd_ch.now_time : cmd_ch.event_time;
    new_entry.etype = cmd_ch.event_type;
    new_entry.first_value = cmd_ch.first_value;
    new_entry.second_value = cmd_ch.second_value;
    new_entry.length = cmd_ch.payload_length;
    new_entry.handle = cmd_ch.payload_handle;

    merged_entry = tail;
    merged_entry.first_value = tail.first_value + cmd_ch.first_value;
    merged_entry.second_value = tail.second_value + cmd_ch.second_value;

    // The tail register is the newest entry whenever the queue is not empty.
    do_merge = is_enq && (cmd_ch.event_type == ieq_pkg::TYPE_MOUSE) && !empty &&
               (tail.etype == ieq_pkg::TYPE_MOUSE);

    wr_en = accept && is_enq;
    wr_addr = do_merge ? newest_slot : wr_slot;
    wr_data = do_merge ? merged_entry : new_entry;
    tail_next = wr_en ? wr_data : tail;

    wp_next = wp;
    rp_next = rp;
    if (accept) begin
      if (is_enq && !do_merge) begin
        wp_next = (wp == PTR_LAST) ? '0 : (wp + 1'b1);
      end
      if ((is_enq && !do_merge && full) || (!is_enq && !empty)) begin
        rp_next = (rp == PTR_LAST) ? '0 : (rp + 1'b1);
      end
    end

    rd_addr = SW'((rp_next >= DEPTH_P) ? (rp_next - DEPTH_P) : rp_next);
    hit_next = wr_en && (wr_addr == rd_addr);
  end

  // A write to the slot being prefetched lands in the tail register too.
  assign head = hit ? tail : mem_rdata;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_rdata <= mem[rd_addr];
  end

  // When full, the slot being overwritten is the oldest one, i.e. the head.
  always_comb begin
    res_next = '0;
    if (is_enq) begin
      res_next.merged = do_merge;
      res_next.overflow_dropped = !do_merge && full;
      if (!do_merge && full) begin
        res_next.dropped_payload_handle = head.handle;
      end
    end else if (!empty) begin
      res_next.event_present = 1'b1;
      res_next.out_time = head.etime;
      res_next.out_type = head.etype;
      res_next.out_first_value = head.first_value;
      res_next.out_second_value = head.second_value;
      res_next.out_payload_length = head.length;
      res_next.out_payload_handle = head.handle;
    end else begin
      res_next.out_time = cmd_ch.now_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      hit <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      wp <= wp_next;
      rp <= rp_next;
      hit <= hit_next;
      if (accept) begin
        res_valid <= 1'b1;
      end else if (res_ch.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tail <= tail_next;
    if (accept) begin
      res <= res_next;
    end
  end

  assign cmd_ch.ready = !res_valid || res_ch.ready;

  assign res_ch.valid = res_valid;
  assign res_ch.event_present = res.event_present;
  assign res_ch.out_time = res.out_time;
  assign res_ch.out_type = res.out_type;
  assign res_ch.out_first_value = res.out_first_value;
  assign res_ch.out_second_value = res.out_second_value;
  assign res_ch.out_payload_length = res.out_payload_length;
  assign res_ch.out_payload_handle = res.out_payload_handle;
  assign res_ch.merged = res.merged;
  assign res_ch.overflow_dropped = res.overflow_dropped;
  assign res_ch.dropped_payload_handle = res.dropped_payload_handle;

  `IEQ_ASSERT_NOW(a_fill_bound, clk, rst, 1'b1, fill <= DEPTH_P)
  `IEQ_ASSERT_NEXT(a_merge_keeps_ptrs, clk, rst, accept && do_merge, $stable(wp) && $stable(rp))
  `IEQ_ASSERT_NEXT(a_overflow_stays_full, clk, rst, accept && is_enq && !do_merge && full, fill == DEPTH_P)
  `IEQ_ASSERT_NEXT(a_empty_dequeue, clk, rst, accept && !is_enq && empty, res_valid && !res.event_present && fill == '0)

endmodule
